[rtl/core/rcd_pkg.sv]
// shared types, constants and the transition step table of the encoder decoder
// no dependencies
package rcd_pkg;

    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_PRESS  = 2'd2,
        MODE_INIT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_PPC  = 2'd0,
        REG_REV  = 2'd1,
        REG_DEB  = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_CLAMP,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [7:0]  ppc;
        logic        rev;
        logic [15:0] deb;
    } t_cfg;

    typedef struct packed {
        logic load_item;
        logic div_load;
        logic div_step;
        logic clamp;
        logic mul;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    localparam logic [7:0] PPC_RST = 8'd2;
    localparam logic [15:0] DEB_RST = 16'd50;
    localparam logic signed [15:0] CLICK_MAX = 16'sh7FFF;
    localparam logic signed [15:0] CLICK_MIN = 16'sh8000;

    // bounce-tolerant quadrature step, index is {old phase, new pins}
    function automatic logic signed [2:0] step_lut(input logic [3:0] idx);
        logic signed [2:0] s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: s = 3'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = -3'sd1;
            4'd9: s = 3'sd2;
            4'd6: s = -3'sd2;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/rcd_if.sv]
// request and result channels of the encoder decoder
// no dependencies
interface rcd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        phase_a;
    logic        phase_b;
    logic        button_raw;
    logic [31:0] now_ms;

    modport source (output valid, mode, phase_a, phase_b, button_raw, now_ms, input ready);
    modport sink (input valid, mode, phase_a, phase_b, button_raw, now_ms, output ready);
endinterface

interface rcd_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] clicks;
    logic               pressed;

    modport source (output valid, clicks, pressed, input ready);
    modport sink (input valid, clicks, pressed, output ready);
endinterface

[rtl/core/rotary_encoder_click_decoder_core.sv]
// quadrature encoder decoder with debounced button, top level
// sample, read press and initialise go from idle to fin and register their result on commit
// read change also runs load, div, clamp and mul; div uses the one bit per cycle click divider
// throughput: one request in flight; next request taken the cycle after the result is registered
// reset: synchronous active low, clears decoder state and loads default configuration
// depends on rcd_pkg, rcd_if, rcd_cfg, rcd_ctrl and rcd_dpath
module rotary_encoder_click_decoder_core #(
    parameter int COUNT_WIDTH = 16,
    parameter int TICK_WIDTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rcd_req_if.sink                    i_req,
    rcd_rsp_if.source                  o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    rcd_pkg::t_cfg cfg;
    rcd_pkg::t_cmd cmd;
    rcd_pkg::t_sts sts;
    logic          ready;

    assign i_req.ready = ready;

    rcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_mode  (rcd_pkg::t_mode'(i_req.mode)),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    rcd_dpath #(
        .CW (COUNT_WIDTH),
        .TW (TICK_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (rcd_pkg::t_mode'(i_req.mode)),
        .i_pins       ({i_req.phase_b, i_req.phase_a}),
        .i_button_raw (i_req.button_raw),
        .i_now_ms     (i_req.now_ms),
        .o_rsp        (o_rsp)
    );

endmodule

[rtl/core/rcd_cfg.sv]
// apb configuration registers of the encoder decoder
// depends on rcd_pkg
module rcd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output rcd_pkg::t_cfg               o_cfg
);

    rcd_pkg::t_cfg     r_cfg;
    rcd_pkg::t_reg_idx idx;
    logic              wr;

    assign idx    = rcd_pkg::t_reg_idx'(paddr[3:2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppc <= rcd_pkg::PPC_RST;
            r_cfg.rev <= 1'b0;
            r_cfg.deb <= rcd_pkg::DEB_RST;
        end else if (wr) begin
            case (idx)
                rcd_pkg::REG_PPC: r_cfg.ppc <= pwdata[7:0];
                rcd_pkg::REG_REV: r_cfg.rev <= pwdata[0];
                rcd_pkg::REG_DEB: r_cfg.deb <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rcd_pkg::REG_PPC: prdata = {24'd0, r_cfg.ppc};
            rcd_pkg::REG_REV: prdata = {31'd0, r_cfg.rev};
            rcd_pkg::REG_DEB: prdata = {16'd0, r_cfg.deb};
            default: prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/rcd_ctrl.sv]
// sequencing state machine of the encoder decoder
// depends on rcd_pkg
module rcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rcd_pkg::t_mode i_mode,
    input  rcd_pkg::t_sts  i_sts,
    output logic           o_ready,
    output rcd_pkg::t_cmd  o_cmd
);

    rcd_pkg::t_state r_state;
    rcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            rcd_pkg::ST_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_mode == rcd_pkg::MODE_CHANGE) ? rcd_pkg::ST_LOAD
                                                               : rcd_pkg::ST_FIN;
                end
            end
            rcd_pkg::ST_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state = rcd_pkg::ST_DIV;
            end
            rcd_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = rcd_pkg::ST_CLAMP;
                end
            end
            rcd_pkg::ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = rcd_pkg::ST_MUL;
            end
            rcd_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = rcd_pkg::ST_FIN;
            end
            rcd_pkg::ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = rcd_pkg::ST_IDLE;
                end
            end
            default: n_state = rcd_pkg::ST_IDLE;
        endcase
    end

endmodule

[rtl/core/rcd_dpath.sv]
// decoder state, debounce, bit-serial click divider and result register
// depends on rcd_pkg and rcd_if
module rcd_dpath #(
    parameter int CW = 16,
    parameter int TW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcd_pkg::t_cfg     i_cfg,
    input  rcd_pkg::t_cmd     i_cmd,
    output rcd_pkg::t_sts     o_sts,
    input  rcd_pkg::t_mode    i_mode,
    input  logic [1:0]        i_pins,
    input  logic              i_button_raw,
    input  logic [31:0]       i_now_ms,
    rcd_rsp_if.source         o_rsp
);

    localparam int XW   = CW + 10;
    localparam int EW   = (CW + 3 > 17) ? CW + 3 : 17;
    localparam int YW   = (CW > 26) ? CW : 26;
    localparam int CNTW = $clog2(CW);

    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    // latched request
    rcd_pkg::t_mode r_mode;
    logic [1:0]     r_pins;
    logic           r_press_now;
    logic [TW-1:0]  r_now;

    // decoder state
    logic [1:0]           r_phase, n_phase;
    logic signed [CW-1:0] r_count, n_count;
    logic                 r_btn, n_btn;
    logic [TW-1:0]        r_last, n_last;
    logic                 r_pend, n_pend;

    // divider and click path
    logic [CW-1:0]         r_quo;
    logic [7:0]            r_rem;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_neg;
    logic signed [15:0]    r_rep;
    logic signed [16:0]    r_r2;
    logic signed [25:0]    r_prod;

    // result register
    logic                  r_out_valid;
    logic signed [15:0]    r_clicks;
    logic                  r_pressed;

    logic [7:0]            ppc_eff;
    logic [7:0]            h;
    logic signed [8:0]     ppc_s;
    logic signed [XW-1:0]  c_x, h_x, p_x;
    logic                  cond_pos, cond_neg;
    logic [CW-1:0]         dividend;
    logic [8:0]            rem_sh;
    logic                  rem_ge;
    logic signed [EW-1:0]  q_x, r_x, rep_x;
    logic signed [15:0]    rep;
    logic signed [16:0]    rep_w;
    logic signed [2:0]     step;
    logic signed [CW:0]    sum;
    logic signed [CW-1:0]  sat;
    logic [TW-1:0]         diff_t;
    logic                  timeout;
    logic signed [YW-1:0]  rest;

    assign ppc_eff = (i_cfg.ppc == 8'd0) ? 8'd1 : i_cfg.ppc;
    assign h       = (ppc_eff - 8'd1) >> 1;
    assign ppc_s   = $signed({1'b0, ppc_eff});

    // rounding decision and dividend magnitude
    assign c_x      = XW'(r_count);
    assign h_x      = $signed(XW'(h));
    assign p_x      = $signed(XW'(ppc_eff));
    assign cond_pos = (c_x + h_x) >= (p_x - h_x);
    assign cond_neg = (c_x - h_x) <= -p_x;

    always_comb begin
        if (cond_pos) begin
            dividend = CW'(c_x + h_x);
        end else if (cond_neg) begin
            dividend = CW'(h_x - c_x);
        end else begin
            dividend = '0;
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[CW-1]};
    assign rem_ge = rem_sh >= {1'b0, ppc_eff};

    // signed quotient, direction and 16 bit saturation
    always_comb begin
        q_x   = $signed(EW'(r_quo));
        r_x   = r_neg ? -q_x : q_x;
        rep_x = i_cfg.rev ? -r_x : r_x;
        if (rep_x > EW'(rcd_pkg::CLICK_MAX)) begin
            rep = rcd_pkg::CLICK_MAX;
        end else if (rep_x < EW'(rcd_pkg::CLICK_MIN)) begin
            rep = rcd_pkg::CLICK_MIN;
        end else begin
            rep = rep_x[15:0];
        end
        rep_w = 17'(rep);
    end

    assign o_sts.div_last = (r_cnt == CNTW'(CW - 1));
    assign o_sts.out_free = !r_out_valid || o_rsp.ready;

    // sample path
    assign step    = rcd_pkg::step_lut({r_phase, r_pins});
    assign sum     = (CW+1)'(r_count) + (CW+1)'(step);
    assign sat     = (sum[CW] != sum[CW-1]) ? (sum[CW] ? CNT_MIN : CNT_MAX) : sum[CW-1:0];
    assign diff_t  = r_now - r_last;
    assign timeout = diff_t > TW'(i_cfg.deb);
    assign rest    = YW'(r_count) - YW'(r_prod);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_btn   = r_btn;
        n_last  = r_last;
        n_pend  = r_pend;
        case (r_mode)
            rcd_pkg::MODE_SAMPLE: begin
                if (step != 3'sd0) begin
                    n_count = sat;
                    n_phase = r_pins;
                end
                if (r_press_now == r_btn) begin
                    n_last = r_now;
                end else if (timeout) begin
                    n_btn  = r_press_now;
                    n_last = r_now;
                    if (r_press_now) begin
                        n_pend = 1'b1;
                    end
                end
            end
            rcd_pkg::MODE_CHANGE: begin
                n_count = rest[CW-1:0];
            end
            rcd_pkg::MODE_PRESS: begin
                n_pend = 1'b0;
            end
            rcd_pkg::MODE_INIT: begin
                n_count = '0;
                n_phase = r_pins;
                n_btn   = r_press_now;
                n_last  = r_now;
                n_pend  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_count     <= '0;
            r_btn       <= 1'b0;
            r_last      <= '0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_btn       <= n_btn;
                r_last      <= n_last;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.div_load) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode      <= i_mode;
            r_pins      <= i_pins;
            r_press_now <= ~i_button_raw;
            r_now       <= i_now_ms[TW-1:0];
        end
        if (i_cmd.div_load) begin
            r_quo <= dividend;
            r_rem <= '0;
            r_neg <= cond_neg & ~cond_pos;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[CW-2:0], rem_ge};
            r_rem <= rem_ge ? 8'(rem_sh - {1'b0, ppc_eff}) : rem_sh[7:0];
        end
        if (i_cmd.clamp) begin
            r_rep <= rep;
            r_r2  <= i_cfg.rev ? -rep_w : rep_w;
        end
        if (i_cmd.mul) begin
            r_prod <= 26'(r_r2) * 26'(ppc_s);
        end
        if (i_cmd.commit) begin
            r_clicks  <= (r_mode == rcd_pkg::MODE_CHANGE) ? r_rep : 16'sd0;
            r_pressed <= (r_mode == rcd_pkg::MODE_PRESS) ? r_pend : 1'b0;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.clicks  = r_clicks;
    assign o_rsp.pressed = r_pressed;

endmodule
